// ===== rtl/qte_pkg.sv =====
// ============================================================================
// qte_pkg: shared types and constants
// Widths, stage counts, arctangent table and the structs passed between the
// quaternion-to-Euler pipeline sections.
// ============================================================================
package qte_pkg;

    localparam int SUM_W         = 35;
    localparam int RAD_W         = 61;
    localparam int SQ_W          = 62;
    localparam int ROOT_W        = 31;
    localparam int XY_W          = 58;
    localparam int ANG_W         = 32;
    localparam int PRE_SHIFT     = 20;
    localparam int CORDIC_ITERS  = 32;

    localparam int FRONT_STAGES  = 5;
    localparam int SQRT_STAGES   = 31;
    localparam int CORDIC_STAGES = CORDIC_ITERS + 1;
    localparam int PIPE_DEPTH    = FRONT_STAGES + SQRT_STAGES + CORDIC_STAGES + 1;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = 35'sd1073741824;
    localparam logic [RAD_W-1:0]        RAD_TOP = 61'h1000_0000_0000_0000;

    localparam logic [ANG_W-1:0] QUARTER_TURN     = 32'h4000_0000;
    localparam logic [ANG_W-1:0] NEG_QUARTER_TURN = 32'hC000_0000;

    localparam logic [ANG_W-1:0] ATAN_TABLE [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] syw;
        logic signed [SUM_W-1:0] cyw;
        logic                    sat_pos;
        logic                    sat_neg;
    } side_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cx;
        logic                    sat_pos;
        logic                    sat_neg;
    } cordic_in_t;

    typedef struct packed {
        logic zero;
        logic sat_pos;
        logic sat_neg;
    } cflag_t;

endpackage

// ===== rtl/qte_quat_if.sv =====
// ============================================================================
// qte_quat_if: quaternion input channel
// Valid/ready channel carrying one Q1.15 quaternion per transaction.
// ============================================================================
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/qte_euler_if.sv =====
// ============================================================================
// qte_euler_if: Euler angle output channel
// Valid/ready channel carrying yaw, pitch and roll per transaction.
// ============================================================================
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;

    modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

// ===== rtl/qte_front.sv =====
// ============================================================================
// qte_front: product and sum stages
// Quaternion products, angle argument sums, pitch saturation flags and the
// radicand 2^60 - sp^2 for the pitch cosine term.
// ============================================================================
module qte_front (
    input  logic                                 clk,
    input  logic [qte_pkg::FRONT_STAGES-1:0]     en,
    input  logic signed [15:0]                   quat_w,
    input  logic signed [15:0]                   quat_x,
    input  logic signed [15:0]                   quat_y,
    input  logic signed [15:0]                   quat_z,
    output qte_pkg::side_t                       side,
    output logic [qte_pkg::RAD_W-1:0]            rad
);

    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;

    logic signed [qte_pkg::SUM_W-1:0] sr_reg, cr_reg, sp_reg, syw_reg, cyw_reg;
    logic signed [qte_pkg::SUM_W-1:0] sr_next, cr_next, sp_next, syw_next, cyw_next;

    qte_pkg::side_t side2_reg, side2_next, side3_reg, side4_reg;
    logic [29:0]    mag_reg, mag_next;
    logic [59:0]    sq_reg, sq_next;
    logic [qte_pkg::RAD_W-1:0] rad_reg, rad_next;

    // stage 0: products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_wx_reg <= 32'(quat_w) * 32'(quat_x);
            p_yz_reg <= 32'(quat_y) * 32'(quat_z);
            p_xx_reg <= 32'(quat_x) * 32'(quat_x);
            p_yy_reg <= 32'(quat_y) * 32'(quat_y);
            p_wy_reg <= 32'(quat_w) * 32'(quat_y);
            p_zx_reg <= 32'(quat_z) * 32'(quat_x);
            p_wz_reg <= 32'(quat_w) * 32'(quat_z);
            p_xy_reg <= 32'(quat_x) * 32'(quat_y);
            p_zz_reg <= 32'(quat_z) * 32'(quat_z);
        end
    end

    // stage 1: argument sums, Q5.30
    always_comb
    begin
        sr_next  = (qte_pkg::SUM_W'(p_wx_reg) + qte_pkg::SUM_W'(p_yz_reg)) <<< 1;
        cr_next  = qte_pkg::ONE_Q30
                 - ((qte_pkg::SUM_W'(p_xx_reg) + qte_pkg::SUM_W'(p_yy_reg)) <<< 1);
        sp_next  = (qte_pkg::SUM_W'(p_wy_reg) - qte_pkg::SUM_W'(p_zx_reg)) <<< 1;
        syw_next = (qte_pkg::SUM_W'(p_wz_reg) + qte_pkg::SUM_W'(p_xy_reg)) <<< 1;
        cyw_next = qte_pkg::ONE_Q30
                 - ((qte_pkg::SUM_W'(p_yy_reg) + qte_pkg::SUM_W'(p_zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sr_reg  <= sr_next;
            cr_reg  <= cr_next;
            sp_reg  <= sp_next;
            syw_reg <= syw_next;
            cyw_reg <= cyw_next;
        end
    end

    // stage 2: saturation and |sp| (only meaningful when unsaturated)
    always_comb
    begin
        side2_next.sr      = sr_reg;
        side2_next.cr      = cr_reg;
        side2_next.sp      = sp_reg;
        side2_next.syw     = syw_reg;
        side2_next.cyw     = cyw_reg;
        side2_next.sat_pos = (sp_reg >= qte_pkg::ONE_Q30);
        side2_next.sat_neg = (sp_reg <= -qte_pkg::ONE_Q30);
        mag_next           = sp_reg[qte_pkg::SUM_W-1] ? 30'(-sp_reg) : 30'(sp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            side2_reg <= side2_next;
            mag_reg   <= mag_next;
        end
    end

    // stage 3: square
    assign sq_next = 60'(mag_reg) * 60'(mag_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            side3_reg <= side2_reg;
            sq_reg    <= sq_next;
        end
    end

    // stage 4: radicand
    assign rad_next = qte_pkg::RAD_TOP - qte_pkg::RAD_W'(sq_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            side4_reg <= side3_reg;
            rad_reg   <= rad_next;
        end
    end

    assign side = side4_reg;
    assign rad  = rad_reg;

endmodule

// ===== rtl/qte_isqrt.sv =====
// ============================================================================
// qte_isqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage; the argument sums
// travel alongside.
// ============================================================================
module qte_isqrt (
    input  logic                               clk,
    input  logic [qte_pkg::SQRT_STAGES-1:0]    en,
    input  logic [qte_pkg::RAD_W-1:0]          rad,
    input  qte_pkg::side_t                     side_in,
    output logic [qte_pkg::ROOT_W-1:0]         root,
    output qte_pkg::side_t                     side_out
);

    logic [qte_pkg::SQ_W-1:0] rem_reg  [qte_pkg::SQRT_STAGES];
    logic [qte_pkg::SQ_W-1:0] res_reg  [qte_pkg::SQRT_STAGES];
    qte_pkg::side_t           side_reg [qte_pkg::SQRT_STAGES];

    for (genvar k = 0; k < qte_pkg::SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [qte_pkg::SQ_W-1:0] BIT_K =
            qte_pkg::SQ_W'(1) << (2 * (qte_pkg::SQRT_STAGES - 1 - k));

        logic [qte_pkg::SQ_W-1:0] rem_in, res_in, trial;
        logic [qte_pkg::SQ_W-1:0] rem_next, res_next;
        qte_pkg::side_t           side_prev;

        if (k == 0)
        begin : g_first
            assign rem_in    = qte_pkg::SQ_W'(rad);
            assign res_in    = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign rem_in    = rem_reg[k-1];
            assign res_in    = res_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT_K;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT_K;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign root     = res_reg[qte_pkg::SQRT_STAGES-1][qte_pkg::ROOT_W-1:0];
    assign side_out = side_reg[qte_pkg::SQRT_STAGES-1];

endmodule

// ===== rtl/qte_cordic.sv =====
// ============================================================================
// qte_cordic: pipelined vectoring CORDIC
// atan2 as a 32-bit binary angle: quarter-turn pre-rotation stage followed by
// one micro-rotation per stage; zero vector and saturation override at exit.
// ============================================================================
module qte_cordic (
    input  logic                                clk,
    input  logic [qte_pkg::CORDIC_STAGES-1:0]   en,
    input  qte_pkg::cordic_in_t                 din,
    output logic [qte_pkg::ANG_W-1:0]           angle
);

    logic signed [qte_pkg::XY_W-1:0] x_reg [qte_pkg::CORDIC_STAGES];
    logic signed [qte_pkg::XY_W-1:0] y_reg [qte_pkg::CORDIC_STAGES];
    logic [qte_pkg::ANG_W-1:0]       z_reg [qte_pkg::CORDIC_STAGES];
    qte_pkg::cflag_t                 f_reg [qte_pkg::CORDIC_STAGES];

    logic signed [qte_pkg::XY_W-1:0] xs, ys, x0_next, y0_next;
    logic [qte_pkg::ANG_W-1:0]       z0_next;
    qte_pkg::cflag_t                 f0_next;
    qte_pkg::cflag_t                 f_last;

    // pre-rotation into the right half-plane
    always_comb
    begin
        xs              = qte_pkg::XY_W'(din.cx) <<< qte_pkg::PRE_SHIFT;
        ys              = qte_pkg::XY_W'(din.sy) <<< qte_pkg::PRE_SHIFT;
        f0_next.zero    = (din.sy == '0) && (din.cx == '0);
        f0_next.sat_pos = din.sat_pos;
        f0_next.sat_neg = din.sat_neg;
        x0_next         = xs;
        y0_next         = ys;
        z0_next         = '0;
        if (xs[qte_pkg::XY_W-1])
        begin
            if (!ys[qte_pkg::XY_W-1])
            begin
                x0_next = ys;
                y0_next = -xs;
                z0_next = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                x0_next = -ys;
                y0_next = xs;
                z0_next = qte_pkg::NEG_QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            f_reg[0] <= f0_next;
        end
    end

    for (genvar k = 1; k < qte_pkg::CORDIC_STAGES; k++)
    begin : g_iter
        logic signed [qte_pkg::XY_W-1:0] dx, dy, x_next, y_next;
        logic [qte_pkg::ANG_W-1:0]       z_next;

        always_comb
        begin
            dx = y_reg[k-1] >>> (k - 1);
            dy = x_reg[k-1] >>> (k - 1);
            if (!y_reg[k-1][qte_pkg::XY_W-1])
            begin
                x_next = x_reg[k-1] + dx;
                y_next = y_reg[k-1] - dy;
                z_next = z_reg[k-1] + qte_pkg::ATAN_TABLE[k-1];
            end
            else
            begin
                x_next = x_reg[k-1] - dx;
                y_next = y_reg[k-1] + dy;
                z_next = z_reg[k-1] - qte_pkg::ATAN_TABLE[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
                f_reg[k] <= f_reg[k-1];
            end
        end
    end

    assign f_last = f_reg[qte_pkg::CORDIC_STAGES-1];

    always_comb
    begin
        if (f_last.sat_pos)
            angle = qte_pkg::QUARTER_TURN;
        else if (f_last.sat_neg)
            angle = qte_pkg::NEG_QUARTER_TURN;
        else if (f_last.zero)
            angle = '0;
        else
            angle = z_reg[qte_pkg::CORDIC_STAGES-1];
    end

endmodule

// ===== rtl/quaternion_to_euler_zyx_top.sv =====
// Throughput: one transaction per cycle while the output is not stalled;
// every stage advances on its own valid/ready, so bubbles collapse and a
// stalled output holds only the full stages behind it. Depth set by the
// 31-stage square root and 33-stage CORDIC.
// Reset clears the stage valid bits only; payload registers are not reset.
// ============================================================================
// quaternion_to_euler_zyx_top: quaternion to Z-Y-X Euler angles
// Products and sums, pitch cosine by integer square root, three parallel
// CORDIC atan2 pipelines and a rounding output register.
// ============================================================================
module quaternion_to_euler_zyx_top #(
    parameter int ANGLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    qte_quat_if.sink      quat,
    qte_euler_if.source   euler
);

    localparam int          DEPTH = qte_pkg::PIPE_DEPTH;
    localparam int          SQ0   = qte_pkg::FRONT_STAGES;
    localparam int          CD0   = SQ0 + qte_pkg::SQRT_STAGES;
    localparam int          OUTS  = CD0 + qte_pkg::CORDIC_STAGES;
    localparam int          SHIFT = 32 - ANGLE_BITS;
    localparam logic [32:0] HALF  = (33'd1 << SHIFT) >> 1;

    logic [DEPTH-1:0] vld_reg, vld_next, en;

    qte_pkg::side_t              side_front, side_root;
    logic [qte_pkg::RAD_W-1:0]   rad;
    logic [qte_pkg::ROOT_W-1:0]  root;
    qte_pkg::cordic_in_t         roll_in, yaw_in, pitch_in;
    logic [qte_pkg::ANG_W-1:0]   roll_z, yaw_z, pitch_z;

    logic signed [15:0] yaw_reg, pitch_reg, roll_reg;

    function automatic logic signed [15:0] to_field(input logic [qte_pkg::ANG_W-1:0] a);
        logic [32:0]                  s;
        logic signed [ANGLE_BITS-1:0] r;
        s = {1'b0, a} + HALF;
        r = s[SHIFT +: ANGLE_BITS];
        return 16'(r);
    endfunction

    // stage advance chain
    assign en[DEPTH-1] = !vld_reg[DEPTH-1] || euler.ready;
    for (genvar i = 0; i < DEPTH - 1; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    assign vld_next = (en & {vld_reg[DEPTH-2:0], quat.valid}) | (~en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign quat.ready  = en[0];
    assign euler.valid = vld_reg[DEPTH-1];

    qte_front u_front (
        .clk    (clk),
        .en     (en[SQ0-1:0]),
        .quat_w (quat.quat_w),
        .quat_x (quat.quat_x),
        .quat_y (quat.quat_y),
        .quat_z (quat.quat_z),
        .side   (side_front),
        .rad    (rad)
    );

    qte_isqrt u_isqrt (
        .clk      (clk),
        .en       (en[CD0-1:SQ0]),
        .rad      (rad),
        .side_in  (side_front),
        .root     (root),
        .side_out (side_root)
    );

    always_comb
    begin
        roll_in.sy       = side_root.sr;
        roll_in.cx       = side_root.cr;
        roll_in.sat_pos  = 1'b0;
        roll_in.sat_neg  = 1'b0;
        yaw_in.sy        = side_root.syw;
        yaw_in.cx        = side_root.cyw;
        yaw_in.sat_pos   = 1'b0;
        yaw_in.sat_neg   = 1'b0;
        pitch_in.sy      = side_root.sp;
        pitch_in.cx      = $signed(qte_pkg::SUM_W'(root));
        pitch_in.sat_pos = side_root.sat_pos;
        pitch_in.sat_neg = side_root.sat_neg;
    end

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en[OUTS-1:CD0]),
        .din   (roll_in),
        .angle (roll_z)
    );

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en[OUTS-1:CD0]),
        .din   (yaw_in),
        .angle (yaw_z)
    );

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en[OUTS-1:CD0]),
        .din   (pitch_in),
        .angle (pitch_z)
    );

    always_ff @(posedge clk)
    begin
        if (en[OUTS])
        begin
            yaw_reg   <= to_field(yaw_z);
            pitch_reg <= to_field(pitch_z);
            roll_reg  <= to_field(roll_z);
        end
    end

    assign euler.yaw_angle   = yaw_reg;
    assign euler.pitch_angle = pitch_reg;
    assign euler.roll_angle  = roll_reg;

endmodule

// ===== rtl/qte_checker.sv =====
// ============================================================================
// qte_checker: port-level checks
// Output hold under back-pressure, input readiness when the output is empty
// and pitch range.
// ============================================================================
module qte_checker #(
    parameter int ANGLE_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] yaw_angle,
    input logic signed [15:0] pitch_angle,
    input logic signed [15:0] roll_angle
);

    localparam int QUARTER = (ANGLE_BITS > 16) ? 16384 : (1 << (ANGLE_BITS - 2));

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(yaw_angle) && $stable(pitch_angle) && $stable(roll_angle))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ANGLE_BITS <= 16) |->
            (int'(pitch_angle) <= QUARTER) && (int'(pitch_angle) >= -QUARTER))
        else $error("pitch outside quarter turn");

endmodule

bind quaternion_to_euler_zyx_top qte_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_qte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (quat.ready),
    .out_valid   (euler.valid),
    .out_ready   (euler.ready),
    .yaw_angle   (euler.yaw_angle),
    .pitch_angle (euler.pitch_angle),
    .roll_angle  (euler.roll_angle)
);

// ===== tb/quaternion_to_euler_zyx_top_tb.sv =====
// ============================================================================
// quaternion_to_euler_zyx_top_tb: self-checking bench for the Euler converter
// Directed quaternions from a table, then random unit, near-gimbal and raw
// ones, under several idling phases and a long output hold-off. Every result
// field is compared with an in-bench fixed-point model or a table-given pitch.
// ============================================================================
module quaternion_to_euler_zyx_top_tb;

    localparam int ANGLE_BITS = 16;
    localparam int LATENCY    = qte_pkg::PIPE_DEPTH + 4;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 pitch_known;
        logic signed [15:0] pitch;
    } quat_item_t;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qte_quat_if  quat ();
    qte_euler_if euler ();

    quaternion_to_euler_zyx_top #(.ANGLE_BITS(ANGLE_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat),
        .euler (euler)
    );

    quat_item_t pending_quats[$];
    euler_t     expected_angles[$];
    int         send_idle_pct  = 0;
    int         rx_stall_pct   = 0;
    bit         hold_rx        = 1'b0;
    bit         pause_tx       = 1'b0;
    bit         failed         = 1'b0;
    int         idle_cycles    = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] bam_atan2(longint sy, longint cx);
        longint      xv;
        longint      yv;
        longint      t;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        acc = '0;
        if (sy == 0 && cx == 0)
            return '0;
        xv = cx * 1048576;
        yv = sy * 1048576;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t = xv; xv = yv; yv = -t; acc = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                t = xv; xv = -yv; yv = t; acc = qte_pkg::NEG_QUARTER_TURN;
            end
        end
        for (int i = 0; i < qte_pkg::CORDIC_ITERS; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv += dx; yv -= dy; acc += qte_pkg::ATAN_TABLE[i];
            end
            else
            begin
                xv -= dx; yv += dy; acc -= qte_pkg::ATAN_TABLE[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned one_bit;
        rem = n;
        res = 0;
        one_bit = 64'd1 << 62;
        while (one_bit > rem)
            one_bit >>= 2;
        while (one_bit != 0)
        begin
            if (rem >= res + one_bit)
            begin
                rem -= res + one_bit;
                res = (res >> 1) + one_bit;
            end
            else
                res >>= 1;
            one_bit >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] round_angle(logic [31:0] a);
        logic [32:0] r;
        r = {1'b0, a} + 33'h8000;
        return r[31:16];
    endfunction

    function automatic euler_t euler_of(quat_item_t q);
        longint          w;
        longint          x;
        longint          y;
        longint          z;
        longint          one;
        longint          sp;
        longint unsigned c;
        logic [31:0]     pitch_bam;
        euler_t          e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        one = 64'sd1 <<< 30;
        sp = 2 * (w * y - z * x);
        if (sp >= one)
            pitch_bam = qte_pkg::QUARTER_TURN;
        else if (sp <= -one)
            pitch_bam = qte_pkg::NEG_QUARTER_TURN;
        else
        begin
            c = int_sqrt((64'd1 << 60) - longint'(sp * sp));
            pitch_bam = bam_atan2(sp, longint'(c));
        end
        e.roll  = round_angle(bam_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
        e.yaw   = round_angle(bam_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
        e.pitch = round_angle(pitch_bam);
        return e;
    endfunction

    // Source side: hold an offered transaction until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
        begin
            quat.valid  <= 1'b0;
            quat.quat_w <= '0;
            quat.quat_x <= '0;
            quat.quat_y <= '0;
            quat.quat_z <= '0;
        end
        else
        begin
            if (quat.valid && quat.ready)
            begin
                e = euler_of(pending_quats[0]);
                if (pending_quats[0].pitch_known)
                    e.pitch = pending_quats[0].pitch;
                expected_angles.push_back(e);
                void'(pending_quats.pop_front());
            end
            if (quat.valid && !quat.ready)
                quat.valid <= 1'b1;
            else if (pending_quats.size() != 0 && !pause_tx &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                quat.valid  <= 1'b1;
                quat.quat_w <= pending_quats[0].w;
                quat.quat_x <= pending_quats[0].x;
                quat.quat_y <= pending_quats[0].y;
                quat.quat_z <= pending_quats[0].z;
            end
            else
                quat.valid <= 1'b0;
        end
    end

    // Sink side: check each Euler transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
            euler.ready <= 1'b0;
        else
        begin
            if (euler.valid && euler.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("%0t unexpected transaction yaw %0d pitch %0d roll %0d", $time,
                             euler.yaw_angle, euler.pitch_angle, euler.roll_angle);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (euler.yaw_angle !== e.yaw)
                    begin
                        $display("%0t yaw expected %0d actual %0d", $time, e.yaw,
                                 euler.yaw_angle);
                        failed = 1'b1;
                    end
                    if (euler.pitch_angle !== e.pitch)
                    begin
                        $display("%0t pitch expected %0d actual %0d", $time, e.pitch,
                                 euler.pitch_angle);
                        failed = 1'b1;
                    end
                    if (euler.roll_angle !== e.roll)
                    begin
                        $display("%0t roll expected %0d actual %0d", $time, e.roll,
                                 euler.roll_angle);
                        failed = 1'b1;
                    end
                end
            end
            euler.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((quat.valid && quat.ready) || (euler.valid && euler.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic quat_item_t raw_quat();
        quat_item_t q;
        q.w = 16'($urandom); q.x = 16'($urandom); q.y = 16'($urandom); q.z = 16'($urandom);
        q.pitch_known = 1'b0;
        q.pitch = '0;
        return q;
    endfunction

    function automatic quat_item_t unit_quat();
        quat_item_t q;
        real        a, b, c, d, n;
        a = real'($urandom_range(0, 65534)) - 32767.0;
        b = real'($urandom_range(0, 65534)) - 32767.0;
        c = real'($urandom_range(0, 65534)) - 32767.0;
        d = real'($urandom_range(0, 65534)) - 32767.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 32767.0; n = 32767.0;
        end
        q.w = 16'($rtoi(a * 32767.0 / n));
        q.x = 16'($rtoi(b * 32767.0 / n));
        q.y = 16'($rtoi(c * 32767.0 / n));
        q.z = 16'($rtoi(d * 32767.0 / n));
        q.pitch_known = 1'b0;
        q.pitch = '0;
        return q;
    endfunction

    // Near gimbal lock: 2(wy - zx) close to plus or minus one.
    function automatic quat_item_t gimbal_quat();
        quat_item_t q;
        int         s;
        s = $urandom_range(0, 1) ? 1 : -1;
        q.w = 16'(23170 + $urandom_range(0, 6) - 3);
        q.y = 16'(s * (23170 + $urandom_range(0, 6) - 3));
        q.x = 16'($urandom_range(0, 8) - 4);
        q.z = 16'($urandom_range(0, 8) - 4);
        q.pitch_known = 1'b0;
        q.pitch = '0;
        return q;
    endfunction

    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                pending_quats.push_back(unit_quat());
            else if (r < 75)
                pending_quats.push_back(gimbal_quat());
            else
                pending_quats.push_back(raw_quat());
        end
    endtask

    task automatic drain();
        while (pending_quats.size() != 0 || expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        queue_random(n);
        drain();
    endtask

    localparam int N_DIRECTED = 14;
    quat_item_t directed_quats [N_DIRECTED] = '{
        '{16'sd32767,  16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd23171,  16'sd0,      16'sd23171,  16'sd0,      1'b1, 16'sd16384},
        '{16'sd23171,  16'sd0,     -16'sd23171,  16'sd0,      1'b1, -16'sd16384},
        '{16'sd32767,  16'sd0,      16'sd32767,  16'sd0,      1'b1, 16'sd16384},
        '{-16'sd32768, 16'sd0,      16'sd32767,  16'sd0,      1'b1, -16'sd16384},
        '{16'sd0,      16'sd32767,  16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd0,      16'sd32767,  1'b0, 16'sd0},
        '{16'sd23170,  16'sd0,      16'sd23170,  16'sd0,      1'b0, 16'sd0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 16'sd0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 16'sd0},
        '{16'sd16384,  16'sd16384,  16'sd16384,  16'sd16384,  1'b0, 16'sd0},
        '{16'sd23170,  16'sd23170,  16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sh5555,  -16'sh5556,   16'sh2AAA,  -16'sh2AAB,   1'b0, 16'sd0}
    };

    initial
    begin
        int hold_count;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_quats[i])
            pending_quats.push_back(directed_quats[i]);
        drain();

        run_phase(0, 0, 250);
        run_phase(81, 0, 200);
        run_phase(0, 81, 200);
        run_phase(36, 36, 200);

        // Long output hold-off while the source keeps offering.
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        queue_random(150);
        hold_rx = 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_LEN)
        begin
            @(posedge clk);
            hold_count++;
        end
        hold_rx = 1'b0;
        drain();

        // Source pauses mid-stream until everything in flight has come out.
        queue_random(60);
        repeat (20) @(posedge clk);
        pause_tx = 1'b1;
        while (expected_angles.size() != 0)
            @(posedge clk);
        pause_tx = 1'b0;
        drain();

        repeat (LATENCY) @(posedge clk);
        if (!failed && expected_angles.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
